// ----- rtl/blm_pkg.sv -----
`timescale 1ns / 1ps

package blm_pkg;

    // Default batch length, a power of two.
    localparam int unsigned SAMPLE_COUNT_DEF = 16;

    // Field widths.
    localparam int unsigned ADC_W    = 12;
    localparam int unsigned MV_W     = 16;
    localparam int unsigned HYST_W   = 12;
    localparam int unsigned ALPHA_W  = 9;
    localparam int unsigned GAIN_W   = 24;
    localparam int unsigned FILT_W   = 24;
    localparam int unsigned LEVEL_W  = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    // Shared multiplier operand and product widths.
    localparam int unsigned MUL_A_W = 24;
    localparam int unsigned MUL_B_W = 12;
    localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

    // Battery level codes.
    localparam logic [LEVEL_W-1:0] LEVEL_GOOD = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_WARN = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HYST      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd5;

    // Register reset values.
    localparam logic [MV_W-1:0]    LOW_THR_RST  = 16'd6600;
    localparam logic [MV_W-1:0]    WARN_THR_RST = 16'd7000;
    localparam logic [HYST_W-1:0]  HYST_RST     = 12'd200;
    localparam logic [MV_W-1:0]    DEBOUNCE_RST = 16'd10;
    localparam logic [ALPHA_W-1:0] ALPHA_RST    = 9'd26;
    localparam logic [GAIN_W-1:0]  GAIN_RST     = 24'd158440;

    // Unity weight in Q8.
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

    // Thresholds handed to the classifier.
    typedef struct packed {
        logic [MV_W-1:0]   low_mv;
        logic [MV_W-1:0]   warn_mv;
        logic [HYST_W-1:0] hyst_mv;
        logic [MV_W-1:0]   debounce;
    } thr_t;

    // Classifier decision.
    typedef struct packed {
        logic [MV_W-1:0]    low_run;
        logic [LEVEL_W-1:0] level;
    } cls_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_GAIN  = 5'b00010,
        ST_NEW   = 5'b00100,
        ST_OLD   = 5'b01000,
        ST_CLASS = 5'b10000
    } state_t;

endpackage

// ----- rtl/battery_level_monitor.sv -----
`timescale 1ns / 1ps

// Battery level monitor.
// Samples arrive on the s_axis request channel, one 12-bit reading each.
// Samples are summed in batches of SAMPLE_COUNT; a sample that does not close
// a batch leaves the block idle, and tready stays high for the next one.
// The sample that closes a batch starts a sequence (scale, new weight, old
// weight, classify) on one shared 24 x 12 multiplier; tready is low during
// it. Each result carries the filtered voltage in mV and the level code.
// Results sit in an output register; if the receiver stalls, the block keeps
// taking samples until the next batch closes, then waits in the classify
// step until the register is free.
// Register writes use the cfg channel, always ready, and are meant while the
// block is idle. Writing the low threshold reloads the filter from it.
// Reset (rst_n low) restores the default registers, empties the batch,
// loads the filter from the default low threshold and sets the level to good.

module battery_level_monitor
    import blm_pkg::*;
#(
    parameter int unsigned SAMPLE_COUNT = SAMPLE_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Sample requests. tdata: [11:0] adc_sample, [15:12] zero.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,
    // Results. tdata: [15:0] filtered_mv, [17:16] battery_level, [23:18] zero.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,
    // Register writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned LOG2_N = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 0;
    localparam int unsigned CNT_W  = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
    localparam int unsigned SUM_W  = ADC_W + LOG2_N;
    localparam int unsigned ACC_W  = 33;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_COUNT - 1);

    // Configuration registers.
    logic [MV_W-1:0]    low_thr_reg,  low_thr_next;
    logic [MV_W-1:0]    warn_thr_reg, warn_thr_next;
    logic [HYST_W-1:0]  hyst_reg,     hyst_next;
    logic [MV_W-1:0]    debounce_reg, debounce_next;
    logic [ALPHA_W-1:0] alpha_reg,    alpha_next;
    logic [GAIN_W-1:0]  gain_reg,     gain_next;

    // Datapath and control state.
    state_t             state_reg,   state_next;
    logic [SUM_W-1:0]   sum_reg,     sum_next;
    logic [CNT_W-1:0]   count_reg,   count_next;
    logic [ADC_W-1:0]   avg_reg,     avg_next;
    logic [FILT_W-1:0]  reading_reg, reading_next;
    logic [ACC_W-1:0]   acc_reg,     acc_next;
    logic [FILT_W-1:0]  filter_reg,  filter_next;
    logic [MV_W-1:0]    low_run_reg, low_run_next;
    logic [LEVEL_W-1:0] level_reg,   level_next;
    logic               out_valid_reg, out_valid_next;
    logic [MV_W-1:0]    out_mv_reg,  out_mv_next;

    logic               in_fire;
    logic               cfg_fire;
    logic               out_load;
    logic [SUM_W-1:0]   sum_add;
    logic [ALPHA_W-1:0] alpha_eff;
    logic [ALPHA_W-1:0] alpha_rest;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;
    logic [ACC_W-1:0]   acc_sum;
    thr_t               thr;
    cls_t               cls;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_ready = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_CLASS) && (!out_valid_reg || m_axis_tready);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, level_reg, out_mv_reg};

    // Filter weights; weights above unity act as unity.
    assign alpha_eff  = alpha_reg[ALPHA_W-1] ? ALPHA_ONE : alpha_reg;
    assign alpha_rest = ALPHA_ONE - alpha_eff;

    assign sum_add = sum_reg + SUM_W'(s_axis_tdata[ADC_W-1:0]);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        unique case (state_reg)
            ST_GAIN:
            begin
                mul_a = gain_reg;
                mul_b = avg_reg;
            end
            ST_NEW:
            begin
                mul_a = reading_reg;
                mul_b = MUL_B_W'(alpha_eff);
            end
            ST_OLD:
            begin
                mul_a = filter_reg;
                mul_b = MUL_B_W'(alpha_rest);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    blm_mul u_mul
    (
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p)
    );

    assign acc_sum = acc_reg + mul_p[ACC_W-1:0];

    assign thr.low_mv   = low_thr_reg;
    assign thr.warn_mv  = warn_thr_reg;
    assign thr.hyst_mv  = hyst_reg;
    assign thr.debounce = debounce_reg;

    blm_classify u_classify
    (
        .filter_value (filter_reg),
        .thr          (thr),
        .low_run      (low_run_reg),
        .level        (level_reg),
        .result       (cls)
    );

    // Sequencer and next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        avg_next       = avg_reg;
        reading_next   = reading_reg;
        acc_next       = acc_reg;
        filter_next    = filter_reg;
        low_run_next   = low_run_reg;
        level_next     = level_reg;
        out_mv_next    = out_mv_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (count_reg == CNT_LAST)
                    begin
                        avg_next   = sum_add[SUM_W-1 -: ADC_W];
                        sum_next   = '0;
                        count_next = '0;
                        state_next = ST_GAIN;
                    end
                    else
                    begin
                        sum_next   = sum_add;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_GAIN:
            begin
                // Q8 millivolts, saturated to the filter width.
                if (mul_p[MUL_P_W-1:FILT_W+8] != '0)
                begin
                    reading_next = {FILT_W{1'b1}};
                end
                else
                begin
                    reading_next = mul_p[FILT_W+7:8];
                end
                state_next = ST_NEW;
            end
            ST_NEW:
            begin
                acc_next   = mul_p[ACC_W-1:0];
                state_next = ST_OLD;
            end
            ST_OLD:
            begin
                filter_next = acc_sum[FILT_W+7:8];
                state_next  = ST_CLASS;
            end
            ST_CLASS:
            begin
                if (out_load)
                begin
                    low_run_next   = cls.low_run;
                    level_next     = cls.level;
                    out_mv_next    = filter_reg[FILT_W-1:8];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Loading the low threshold also reloads the filter.
        if (cfg_fire && (cfg_index == REG_LOW_THR))
        begin
            filter_next = {cfg_data[MV_W-1:0], 8'd0};
        end
    end

    // Register writes.
    always_comb
    begin
        low_thr_next  = low_thr_reg;
        warn_thr_next = warn_thr_reg;
        hyst_next     = hyst_reg;
        debounce_next = debounce_reg;
        alpha_next    = alpha_reg;
        gain_next     = gain_reg;
        if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_LOW_THR:  low_thr_next  = cfg_data[MV_W-1:0];
                REG_WARN_THR: warn_thr_next = cfg_data[MV_W-1:0];
                REG_HYST:     hyst_next     = cfg_data[HYST_W-1:0];
                REG_DEBOUNCE: debounce_next = cfg_data[MV_W-1:0];
                REG_ALPHA:    alpha_next    = cfg_data[ALPHA_W-1:0];
                REG_GAIN:     gain_next     = cfg_data[GAIN_W-1:0];
                default:      ;
            endcase
        end
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg   <= LOW_THR_RST;
            warn_thr_reg  <= WARN_THR_RST;
            hyst_reg      <= HYST_RST;
            debounce_reg  <= DEBOUNCE_RST;
            alpha_reg     <= ALPHA_RST;
            gain_reg      <= GAIN_RST;
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            count_reg     <= '0;
            filter_reg    <= {LOW_THR_RST, 8'd0};
            low_run_reg   <= '0;
            level_reg     <= LEVEL_GOOD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            low_thr_reg   <= low_thr_next;
            warn_thr_reg  <= warn_thr_next;
            hyst_reg      <= hyst_next;
            debounce_reg  <= debounce_next;
            alpha_reg     <= alpha_next;
            gain_reg      <= gain_next;
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            filter_reg    <= filter_next;
            low_run_reg   <= low_run_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        avg_reg     <= avg_next;
        reading_reg <= reading_next;
        acc_reg     <= acc_next;
        out_mv_reg  <= out_mv_next;
    end

    // A request that closes a batch starts the arithmetic sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (count_reg == CNT_LAST)) |=> (state_reg == ST_GAIN))
        else $error("closing sample did not start the sequence");

    // A result loaded into the output register leaves the batch empty and the block idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> ((state_reg == ST_IDLE) && (count_reg == '0) && m_axis_tvalid))
        else $error("result load left stale state");

    // Entering the low level needs a nonzero run of low evaluations.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((level_reg == LEVEL_LOW) && ($past(level_reg) != LEVEL_LOW))
            |-> (low_run_reg > debounce_reg))
        else $error("low level declared without debounce");

    // A shown result never carries the unused level code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (level_reg != 2'd3))
        else $error("invalid level code");

endmodule

// ----- rtl/blm_mul.sv -----
`timescale 1ns / 1ps

module blm_mul
    import blm_pkg::*;
(
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic [MUL_P_W-1:0] product
);

    // Unsigned 24 x 12 multiply, shared by the scale and filter steps.
    assign product = MUL_P_W'(a) * MUL_P_W'(b);

endmodule

// ----- rtl/blm_classify.sv -----
`timescale 1ns / 1ps

module blm_classify
    import blm_pkg::*;
(
    input  logic [FILT_W-1:0]  filter_value,
    input  thr_t               thr,
    input  logic [MV_W-1:0]    low_run,
    input  logic [LEVEL_W-1:0] level,
    output cls_t               result
);

    logic [FILT_W-1:0] low_q8;
    logic [FILT_W-1:0] warn_q8;
    logic [FILT_W:0]   good_q8;
    logic [MV_W-1:0]   run_inc;

    // Thresholds in the filter's Q16.8 format.
    assign low_q8  = {thr.low_mv, 8'd0};
    assign warn_q8 = {thr.warn_mv, 8'd0};
    assign good_q8 = {(17'(thr.warn_mv) + 17'(thr.hyst_mv)), 8'd0};

    // Saturating count of consecutive low evaluations.
    assign run_inc = (low_run == {MV_W{1'b1}}) ? low_run : low_run + MV_W'(1);

    // Low with debounce, otherwise warn / good with a hold band between.
    always_comb
    begin
        result.low_run = run_inc;
        result.level   = level;
        if (filter_value <= low_q8)
        begin
            if (run_inc > thr.debounce)
            begin
                result.level = LEVEL_LOW;
            end
        end
        else
        begin
            result.low_run = '0;
            if (filter_value <= warn_q8)
            begin
                result.level = LEVEL_WARN;
            end
            else if ({1'b0, filter_value} >= good_q8)
            begin
                result.level = LEVEL_GOOD;
            end
        end
    end

endmodule
